FILE: rtl/tuparse_pkg.sv
// ----------------------------------------------------------------------------
// tuparse_pkg
// Shared widths, character codes, phase and status types, the queue entry
// layout and the digit decode for the text-to-unsigned parser.
// ----------------------------------------------------------------------------
package tuparse_pkg;

   localparam int TEXT_BITS             = 8;
   localparam int BASE_BITS             = 6;
   localparam int VALUE_PORT_BITS       = 64;
   localparam int OFFSET_BITS           = 16;
   localparam int POS_FIELD_BITS        = 32;
   localparam int VALUE_BITS_DEFAULT    = 64;
   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH           = 4;

   localparam logic [BASE_BITS-1:0] BASE_AUTO    = 6'd0;
   localparam logic [BASE_BITS-1:0] BASE_MIN     = 6'd2;
   localparam logic [BASE_BITS-1:0] BASE_OCTAL   = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_DECIMAL = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX     = 6'd16;
   localparam logic [BASE_BITS-1:0] BASE_MAX     = 6'd36;
   localparam logic [BASE_BITS-1:0] BASE_RESET   = BASE_DECIMAL;
   localparam logic [BASE_BITS-1:0] DIGIT_NONE   = 6'd63;

   localparam logic [TEXT_BITS-1:0] CHAR_TAB     = 8'h09;
   localparam logic [TEXT_BITS-1:0] CHAR_CR      = 8'h0D;
   localparam logic [TEXT_BITS-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [TEXT_BITS-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [TEXT_BITS-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [TEXT_BITS-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [TEXT_BITS-1:0] CHAR_NINE    = 8'h39;
   localparam logic [TEXT_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [TEXT_BITS-1:0] CHAR_UPPER_X = 8'h58;
   localparam logic [TEXT_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [TEXT_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [TEXT_BITS-1:0] CHAR_LOWER_X = 8'h78;
   localparam logic [TEXT_BITS-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [TEXT_BITS-1:0] UPPER_BIAS   = 8'h37;
   localparam logic [TEXT_BITS-1:0] LOWER_BIAS   = 8'h57;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_LEAD,
      PH_ZERO,
      PH_AFTER_X,
      PH_DIGITS,
      PH_DONE
   } parse_phase_type;

   typedef enum logic [1:0] {
      DS_NONE,
      DS_SOME,
      DS_OVER
   } digit_status_type;

   typedef struct packed {
      logic                      digit_valid;
      logic [BASE_BITS-1:0]      digit;
      logic [BASE_BITS-1:0]      base;
      logic                      emit;
      logic                      negative;
      logic [POS_FIELD_BITS-1:0] end_pos;
   } op_type;

   function automatic logic [BASE_BITS-1:0] digit_value(input logic [TEXT_BITS-1:0] c);
      logic [TEXT_BITS-1:0] diff;
      diff = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff = c - CHAR_ZERO;
         return diff[BASE_BITS-1:0];
      end
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         diff = c - LOWER_BIAS;
         return diff[BASE_BITS-1:0];
      end
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         diff = c - UPPER_BIAS;
         return diff[BASE_BITS-1:0];
      end
      return DIGIT_NONE;
   endfunction

endpackage

FILE: rtl/tuparse_req_if.sv
// ----------------------------------------------------------------------------
// tuparse_req_if
// Byte channel into the parser: one character and its end-of-string flag.
// ----------------------------------------------------------------------------
interface tuparse_req_if;
   logic                                valid;
   logic                                ready;
   logic [tuparse_pkg::TEXT_BITS-1:0]   text_byte;
   logic                                final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

FILE: rtl/tuparse_rsp_if.sv
// ----------------------------------------------------------------------------
// tuparse_rsp_if
// Result channel out of the parser: one converted number per string.
// ----------------------------------------------------------------------------
interface tuparse_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [tuparse_pkg::VALUE_PORT_BITS-1:0]   parsed_value;
   logic [tuparse_pkg::OFFSET_BITS-1:0]       end_offset;
   logic                                      overflowed;
   logic                                      had_digits;

   modport source (output valid, output parsed_value, output end_offset,
                   output overflowed, output had_digits, input ready);
   modport sink   (input valid, input parsed_value, input end_offset,
                   input overflowed, input had_digits, output ready);
endinterface

FILE: rtl/tuparse_front.sv
// ----------------------------------------------------------------------------
// tuparse_front
// Byte classifier: tracks whitespace, sign and prefix, checks each digit
// against the radix, counts position and issues digit and result operations.
// ----------------------------------------------------------------------------
module tuparse_front #(
   parameter int POSITION_BITS = tuparse_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [tuparse_pkg::BASE_BITS-1:0]  csr_write_data,
   tuparse_req_if.sink                        req_port,
   output logic                               push_valid,
   input  logic                               push_ready,
   output tuparse_pkg::op_type                push_op
);

   typedef enum logic [2:0] {
      ACT_IDLE,
      ACT_SKIP,
      ACT_SIGN,
      ACT_ZERO,
      ACT_HEX,
      ACT_TAKE
   } action_type;

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   tuparse_pkg::parse_phase_type       phase_ff, phase_in;
   logic                               neg_ff, neg_in;
   logic [tuparse_pkg::BASE_BITS-1:0]  active_base_ff, active_base_in;
   logic [POSITION_BITS-1:0]           pos_ff, pos_in;
   logic [tuparse_pkg::BASE_BITS-1:0]  number_base_ff;

   logic                               accept;
   logic [tuparse_pkg::TEXT_BITS-1:0]  c;
   logic                               fin;
   logic [tuparse_pkg::BASE_BITS-1:0]  d;
   logic                               is_space;
   logic                               is_sign;
   logic                               is_x;
   logic                               zero_prefix;
   action_type                         act;
   logic [tuparse_pkg::BASE_BITS-1:0]  take_base;
   logic                               back_one;
   logic                               digit_ok;
   logic                               rejected;
   logic [POSITION_BITS-1:0]           pos_inc;
   logic [POSITION_BITS-1:0]           end_pos;

   assign req_port.ready = push_ready;
   assign accept         = req_port.valid && push_ready;
   assign c              = req_port.text_byte;
   assign fin            = req_port.final_byte;
   assign d              = tuparse_pkg::digit_value(c);

   assign is_space = (c == tuparse_pkg::CHAR_SPACE) ||
                     (c >= tuparse_pkg::CHAR_TAB && c <= tuparse_pkg::CHAR_CR);
   assign is_sign  = (c == tuparse_pkg::CHAR_MINUS) || (c == tuparse_pkg::CHAR_PLUS);
   assign is_x     = (c == tuparse_pkg::CHAR_LOWER_X) || (c == tuparse_pkg::CHAR_UPPER_X);
   assign zero_prefix = ((number_base_ff == tuparse_pkg::BASE_AUTO) ||
                         (number_base_ff == tuparse_pkg::BASE_HEX)) &&
                        (c == tuparse_pkg::CHAR_ZERO);
   assign pos_inc  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_ONE;

   // Classify the byte against the current phase
   always_comb begin
      act       = ACT_IDLE;
      take_base = active_base_ff;
      back_one  = 1'b0;
      case (phase_ff)
         tuparse_pkg::PH_SPACE, tuparse_pkg::PH_LEAD: begin
            if (phase_ff == tuparse_pkg::PH_SPACE && is_space) begin
               act = ACT_SKIP;
            end else if (phase_ff == tuparse_pkg::PH_SPACE && is_sign) begin
               act = ACT_SIGN;
            end else if (zero_prefix) begin
               act = ACT_ZERO;
            end else begin
               act       = ACT_TAKE;
               take_base = (number_base_ff == tuparse_pkg::BASE_AUTO) ?
                           tuparse_pkg::BASE_DECIMAL : number_base_ff;
            end
         end
         tuparse_pkg::PH_ZERO: begin
            if (is_x) begin
               act = ACT_HEX;
            end else begin
               act       = ACT_TAKE;
               take_base = (active_base_ff == tuparse_pkg::BASE_AUTO) ?
                           tuparse_pkg::BASE_OCTAL : active_base_ff;
            end
         end
         tuparse_pkg::PH_AFTER_X: begin
            act      = ACT_TAKE;
            back_one = 1'b1;
         end
         tuparse_pkg::PH_DIGITS: begin
            act = ACT_TAKE;
         end
         default: begin
            act = ACT_IDLE;
         end
      endcase
   end

   assign digit_ok = (take_base >= tuparse_pkg::BASE_MIN) &&
                     (take_base <= tuparse_pkg::BASE_MAX) && (d < take_base);
   assign rejected = (act == ACT_TAKE) && !digit_ok;

   // Next state
   always_comb begin
      phase_in       = phase_ff;
      neg_in         = neg_ff;
      active_base_in = active_base_ff;
      pos_in         = pos_ff;
      if (accept) begin
         case (act)
            ACT_SKIP: begin
               pos_in = pos_inc;
            end
            ACT_SIGN: begin
               neg_in   = (c == tuparse_pkg::CHAR_MINUS);
               pos_in   = pos_inc;
               phase_in = tuparse_pkg::PH_LEAD;
            end
            ACT_ZERO: begin
               active_base_in = number_base_ff;
               pos_in         = pos_inc;
               phase_in       = tuparse_pkg::PH_ZERO;
            end
            ACT_HEX: begin
               active_base_in = tuparse_pkg::BASE_HEX;
               pos_in         = pos_inc;
               phase_in       = tuparse_pkg::PH_AFTER_X;
            end
            ACT_TAKE: begin
               active_base_in = take_base;
               if (digit_ok) begin
                  pos_in   = pos_inc;
                  phase_in = tuparse_pkg::PH_DIGITS;
               end else begin
                  phase_in = tuparse_pkg::PH_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (fin) begin
            phase_in       = tuparse_pkg::PH_SPACE;
            neg_in         = 1'b0;
            active_base_in = '0;
            pos_in         = '0;
         end
      end
   end

   // Operation towards the back end
   always_comb begin
      if (rejected) begin
         end_pos = back_one ? pos_ff - POS_ONE : pos_ff;
      end else begin
         end_pos = (act == ACT_HEX) ? pos_inc - POS_ONE : pos_inc;
      end
      push_op.digit_valid = (act == ACT_ZERO) || ((act == ACT_TAKE) && digit_ok);
      push_op.digit       = (act == ACT_ZERO) ? '0 : d;
      push_op.base        = (act == ACT_ZERO) ? number_base_ff : take_base;
      push_op.emit        = (act != ACT_IDLE) && (rejected || fin);
      push_op.negative    = neg_ff;
      push_op.end_pos     = tuparse_pkg::POS_FIELD_BITS'(end_pos);
      push_valid          = accept && (push_op.digit_valid || push_op.emit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= tuparse_pkg::PH_SPACE;
         neg_ff         <= 1'b0;
         active_base_ff <= '0;
         pos_ff         <= '0;
         number_base_ff <= tuparse_pkg::BASE_RESET;
      end else begin
         phase_ff       <= phase_in;
         neg_ff         <= neg_in;
         active_base_ff <= active_base_in;
         pos_ff         <= pos_in;
         if (csr_write_enable) begin
            number_base_ff <= csr_write_data;
         end
      end
   end

endmodule

FILE: rtl/tuparse_queue.sv
// ----------------------------------------------------------------------------
// tuparse_queue
// Short first-in first-out buffer of operations between classifier and
// accumulator.
// ----------------------------------------------------------------------------
module tuparse_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  tuparse_pkg::op_type  push_op,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output tuparse_pkg::op_type  pop_op
);

   localparam int AW = $clog2(tuparse_pkg::QUEUE_DEPTH);
   localparam logic [AW:0]   DEPTH_COUNT = (AW + 1)'(tuparse_pkg::QUEUE_DEPTH);
   localparam logic [AW:0]   COUNT_ONE   = (AW + 1)'(1);
   localparam logic [AW-1:0] PTR_ONE     = AW'(1);

   tuparse_pkg::op_type mem_ff [tuparse_pkg::QUEUE_DEPTH];
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [AW:0]         count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != DEPTH_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_ONE : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_ONE : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_ONE;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/tuparse_back.sv
// ----------------------------------------------------------------------------
// tuparse_back
// Accumulator: multiply-add of each digit with overflow saturation, then
// sign and offset finishing into the registered result.
// ----------------------------------------------------------------------------
module tuparse_back #(
   parameter int VALUE_BITS = tuparse_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  tuparse_pkg::op_type  pop_op,
   tuparse_rsp_if.source        rsp_port
);

   localparam int PW = VALUE_BITS + tuparse_pkg::BASE_BITS;
   localparam int OB = tuparse_pkg::OFFSET_BITS;
   localparam int FB = tuparse_pkg::POS_FIELD_BITS;

   logic [VALUE_BITS-1:0]             acc_ff, acc_in;
   tuparse_pkg::digit_status_type     status_ff, status_in;

   logic                              fin_valid_ff, fin_valid_in;
   logic [VALUE_BITS-1:0]             fin_acc_ff;
   tuparse_pkg::digit_status_type     fin_status_ff;
   logic                              fin_neg_ff;
   logic [FB-1:0]                     fin_end_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tuparse_pkg::VALUE_PORT_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [OB-1:0]                     rsp_offset_ff, rsp_offset_in;
   logic                              rsp_over_ff, rsp_over_in;
   logic                              rsp_digits_ff, rsp_digits_in;

   logic [PW-1:0]                     mac;
   logic                              step_over;
   logic [VALUE_BITS-1:0]             acc_new;
   tuparse_pkg::digit_status_type     status_new;
   logic                              out_load;
   logic                              fin_free;
   logic                              do_pop;
   logic [VALUE_BITS-1:0]             final_value;

   assign out_load  = !rsp_valid_ff || rsp_port.ready;
   assign fin_free  = !fin_valid_ff || out_load;
   assign pop_ready = !pop_op.emit || fin_free;
   assign do_pop    = pop_valid && pop_ready;

   assign mac       = PW'(acc_ff) * PW'(pop_op.base) + PW'(pop_op.digit);
   assign step_over = |mac[PW-1:VALUE_BITS];

   always_comb begin
      acc_new    = acc_ff;
      status_new = status_ff;
      if (pop_op.digit_valid && status_ff != tuparse_pkg::DS_OVER) begin
         if (step_over) begin
            acc_new    = '1;
            status_new = tuparse_pkg::DS_OVER;
         end else begin
            acc_new    = mac[VALUE_BITS-1:0];
            status_new = tuparse_pkg::DS_SOME;
         end
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      status_in = status_ff;
      if (do_pop) begin
         if (pop_op.emit) begin
            acc_in    = '0;
            status_in = tuparse_pkg::DS_NONE;
         end else begin
            acc_in    = acc_new;
            status_in = status_new;
         end
      end
      fin_valid_in = (do_pop && pop_op.emit) || (fin_valid_ff && !out_load);
   end

   // Finish: apply sign, saturate the offset
   always_comb begin
      case (fin_status_ff)
         tuparse_pkg::DS_SOME: begin
            final_value = fin_neg_ff ? (~fin_acc_ff + VALUE_BITS'(1)) : fin_acc_ff;
         end
         tuparse_pkg::DS_OVER: begin
            final_value = fin_acc_ff;
         end
         default: begin
            final_value = '0;
         end
      endcase
      rsp_valid_in  = out_load ? fin_valid_ff : rsp_valid_ff;
      rsp_value_in  = tuparse_pkg::VALUE_PORT_BITS'(final_value);
      if (fin_status_ff == tuparse_pkg::DS_NONE) begin
         rsp_offset_in = '0;
      end else if (|fin_end_ff[FB-1:OB]) begin
         rsp_offset_in = '1;
      end else begin
         rsp_offset_in = fin_end_ff[OB-1:0];
      end
      rsp_over_in   = (fin_status_ff == tuparse_pkg::DS_OVER);
      rsp_digits_in = (fin_status_ff != tuparse_pkg::DS_NONE);
   end

   always_ff @(posedge clock) begin
      if (do_pop && pop_op.emit) begin
         fin_acc_ff    <= acc_new;
         fin_status_ff <= status_new;
         fin_neg_ff    <= pop_op.negative;
         fin_end_ff    <= pop_op.end_pos;
      end
      if (out_load && fin_valid_ff) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_over_ff   <= rsp_over_in;
         rsp_digits_ff <= rsp_digits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         status_ff    <= tuparse_pkg::DS_NONE;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         status_ff    <= status_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.parsed_value = rsp_value_ff;
   assign rsp_port.end_offset   = rsp_offset_ff;
   assign rsp_port.overflowed   = rsp_over_ff;
   assign rsp_port.had_digits   = rsp_digits_ff;

endmodule

FILE: rtl/text_to_unsigned_parser.sv
// ----------------------------------------------------------------------------
// text_to_unsigned_parser
// Streaming string-to-unsigned conversion, one character per transfer.
// ----------------------------------------------------------------------------
// Send the characters of a string one per transfer and mark the last with
// final_byte; the block returns one result per string, carrying the value,
// the offset of the first unconsumed character, an overflow flag and a flag
// for whether any digit was taken. A byte is taken every cycle while the
// four-entry operation queue has room; the byte that ends the number passes
// the queue, finish and result registers, and the sustained rate of one byte
// per cycle rests on the combinational multiply-add of the accumulator
// against the radix. Write number_base only between strings.
// ----------------------------------------------------------------------------
module text_to_unsigned_parser #(
   parameter int VALUE_BITS    = tuparse_pkg::VALUE_BITS_DEFAULT,
   parameter int POSITION_BITS = tuparse_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [tuparse_pkg::BASE_BITS-1:0]  csr_write_data,
   tuparse_req_if.sink                        req_port,
   tuparse_rsp_if.source                      rsp_port
);

   logic                 q_push_valid;
   logic                 q_push_ready;
   tuparse_pkg::op_type  q_push_op;
   logic                 q_pop_valid;
   logic                 q_pop_ready;
   tuparse_pkg::op_type  q_pop_op;

   tuparse_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_port         (req_port),
      .push_valid       (q_push_valid),
      .push_ready       (q_push_ready),
      .push_op          (q_push_op)
   );

   tuparse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_op    (q_push_op),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_op     (q_pop_op)
   );

   tuparse_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_op    (q_pop_op),
      .rsp_port  (rsp_port)
   );

`ifndef ASSERT_OFF
   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_port.valid)
      else $error("result presented straight after reset");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push_valid |-> q_push_ready)
      else $error("operation pushed into a full queue");

   a_overflow_has_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.overflowed |-> rsp_port.had_digits)
      else $error("overflow flagged without digits");

   a_empty_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && !rsp_port.had_digits |->
         rsp_port.parsed_value == '0 && rsp_port.end_offset == '0)
      else $error("result without digits carries a value or offset");
`endif

endmodule

FILE: test/text_to_unsigned_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_to_unsigned_parser_test
// Self-checking bench for the streaming string-to-unsigned converter. Strings
// are sent one character per transfer and a local parser predicts the value,
// end offset and flags of each number. Directed strings cover blanks, signs,
// prefixes, invalid radices and the value limits. Phases of random strings
// follow, each at a set radix, most with random gaps on the byte channel and
// random stalls on the result channel; the last phase runs without either.
// ----------------------------------------------------------------------------
module text_to_unsigned_parser_test;

   localparam logic [63:0] ALL_ONES = '1;

   typedef struct {
      logic [63:0] value;
      logic [15:0] offset;
      logic        overflow;
      logic        digits;
   } parsed_number_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                              csr_write_enable;
   logic [tuparse_pkg::BASE_BITS-1:0] csr_write_data;

   tuparse_req_if req_bus ();
   tuparse_rsp_if rsp_bus ();

   text_to_unsigned_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus)
   );

   always #5 clock = ~clock;

   parsed_number_type expected_numbers[$];
   int unsigned failures;
   int unsigned parsed_bytes;
   int unsigned strings_sent;
   int unsigned numbers_checked;
   int unsigned gap_chance;
   int unsigned stall_chance;

   logic [tuparse_pkg::BASE_BITS-1:0] base_reg;
   tuparse_pkg::parse_phase_type      phase;
   logic                              negative;
   logic [tuparse_pkg::BASE_BITS-1:0] radix_now;
   logic [63:0]                       acc;
   tuparse_pkg::digit_status_type     status;
   logic [15:0]                       position;

   function automatic void clear_string();
      phase = tuparse_pkg::PH_SPACE;
      negative = 1'b0;
      radix_now = tuparse_pkg::BASE_AUTO;
      acc = '0;
      status = tuparse_pkg::DS_NONE;
      position = '0;
   endfunction

   function automatic void step_position();
      if (position != 16'hFFFF) begin
         position = position + 16'd1;
      end
   endfunction

   function automatic logic [63:0] char_digit(input logic [7:0] c);
      if (c >= tuparse_pkg::CHAR_ZERO && c <= tuparse_pkg::CHAR_NINE) begin
         return 64'(c - tuparse_pkg::CHAR_ZERO);
      end
      if (c >= tuparse_pkg::CHAR_LOWER_A && c <= tuparse_pkg::CHAR_LOWER_Z) begin
         return 64'(c - tuparse_pkg::CHAR_LOWER_A) + 64'd10;
      end
      if (c >= tuparse_pkg::CHAR_UPPER_A && c <= tuparse_pkg::CHAR_UPPER_Z) begin
         return 64'(c - tuparse_pkg::CHAR_UPPER_A) + 64'd10;
      end
      return 64'd255;
   endfunction

   function automatic logic take_digit(input logic [7:0] c);
      logic [63:0] d;
      logic [63:0] cut;
      logic [63:0] lim;
      d = char_digit(c);
      if (radix_now < tuparse_pkg::BASE_MIN || radix_now > tuparse_pkg::BASE_MAX ||
          d >= 64'(radix_now)) begin
         return 1'b0;
      end
      step_position();
      if (status == tuparse_pkg::DS_OVER) begin
         return 1'b1;
      end
      cut = ALL_ONES / 64'(radix_now);
      lim = ALL_ONES % 64'(radix_now);
      if (acc > cut || (acc == cut && d > lim)) begin
         status = tuparse_pkg::DS_OVER;
         acc = ALL_ONES;
      end else begin
         status = tuparse_pkg::DS_SOME;
         acc = acc * 64'(radix_now) + d;
      end
      return 1'b1;
   endfunction

   function automatic void push_number(input logic [15:0] end_pos);
      parsed_number_type n;
      n.value = acc;
      n.offset = end_pos;
      if (status == tuparse_pkg::DS_OVER) begin
         n.value = ALL_ONES;
      end else if (status == tuparse_pkg::DS_SOME && negative) begin
         n.value = 64'd0 - acc;
      end
      if (status == tuparse_pkg::DS_NONE) begin
         n.value = '0;
         n.offset = '0;
      end
      n.overflow = (status == tuparse_pkg::DS_OVER);
      n.digits = (status != tuparse_pkg::DS_NONE);
      expected_numbers.push_back(n);
   endfunction

   function automatic void parse_char(input logic [7:0] c, input logic last);
      logic        lead;
      logic        rejected;
      logic [15:0] end_pos;
      lead = 1'b0;
      rejected = 1'b0;
      end_pos = '0;
      if (phase == tuparse_pkg::PH_DONE) begin
         if (last) begin
            clear_string();
         end
         return;
      end
      parsed_bytes++;
      case (phase)
         tuparse_pkg::PH_SPACE: begin
            if (c == tuparse_pkg::CHAR_SPACE ||
                (c >= tuparse_pkg::CHAR_TAB && c <= tuparse_pkg::CHAR_CR)) begin
               step_position();
            end else if (c == tuparse_pkg::CHAR_MINUS || c == tuparse_pkg::CHAR_PLUS) begin
               negative = (c == tuparse_pkg::CHAR_MINUS);
               step_position();
               phase = tuparse_pkg::PH_LEAD;
            end else begin
               lead = 1'b1;
            end
         end
         tuparse_pkg::PH_LEAD: begin
            lead = 1'b1;
         end
         tuparse_pkg::PH_ZERO: begin
            if (c == tuparse_pkg::CHAR_LOWER_X || c == tuparse_pkg::CHAR_UPPER_X) begin
               radix_now = tuparse_pkg::BASE_HEX;
               step_position();
               phase = tuparse_pkg::PH_AFTER_X;
            end else begin
               if (radix_now == tuparse_pkg::BASE_AUTO) begin
                  radix_now = tuparse_pkg::BASE_OCTAL;
               end
               phase = tuparse_pkg::PH_DIGITS;
               rejected = !take_digit(c);
               end_pos = position;
            end
         end
         tuparse_pkg::PH_AFTER_X: begin
            phase = tuparse_pkg::PH_DIGITS;
            rejected = !take_digit(c);
            end_pos = position - 16'd1;
         end
         default: begin
            rejected = !take_digit(c);
            end_pos = position;
         end
      endcase
      if (lead) begin
         if ((base_reg == tuparse_pkg::BASE_AUTO || base_reg == tuparse_pkg::BASE_HEX) &&
             c == tuparse_pkg::CHAR_ZERO) begin
            radix_now = base_reg;
            acc = '0;
            status = tuparse_pkg::DS_SOME;
            step_position();
            phase = tuparse_pkg::PH_ZERO;
         end else begin
            radix_now = (base_reg == tuparse_pkg::BASE_AUTO) ? tuparse_pkg::BASE_DECIMAL
                                                             : base_reg;
            phase = tuparse_pkg::PH_DIGITS;
            rejected = !take_digit(c);
            end_pos = position;
         end
      end
      if (rejected) begin
         push_number(end_pos);
         if (last) begin
            clear_string();
         end else begin
            phase = tuparse_pkg::PH_DONE;
         end
      end else if (last) begin
         push_number(phase == tuparse_pkg::PH_AFTER_X ? position - 16'd1 : position);
         clear_string();
      end
   endfunction

   task automatic send_char(input logic [7:0] c, input logic last);
      int unsigned gap;
      gap = 0;
      if (gap_chance != 0 && $urandom_range(1, 100) <= gap_chance) begin
         gap = $urandom_range(1, 15);
      end
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.text_byte <= c;
      req_bus.final_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
      parse_char(c, last);
      if (last) begin
         strings_sent++;
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == s.len() - 1);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_numbers.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_number_base(input logic [tuparse_pkg::BASE_BITS-1:0] value);
      drain_results();
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      base_reg = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random_string();
      logic [7:0]  text[$];
      logic [63:0] m;
      int unsigned radix;
      int unsigned n;
      int unsigned d;
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               text.push_back($urandom_range(0, 5) == 0 ? tuparse_pkg::CHAR_SPACE
                                                         : 8'($urandom_range(9, 13)));
            end
         end
         case ($urandom_range(0, 3))
            0: text.push_back(tuparse_pkg::CHAR_MINUS);
            1: text.push_back(tuparse_pkg::CHAR_PLUS);
            default: ;
         endcase
         radix = base_reg;
         if ((base_reg == tuparse_pkg::BASE_AUTO || base_reg == tuparse_pkg::BASE_HEX) &&
             $urandom_range(0, 2) == 0) begin
            text.push_back(tuparse_pkg::CHAR_ZERO);
            text.push_back($urandom_range(0, 1) ? tuparse_pkg::CHAR_LOWER_X
                                                : tuparse_pkg::CHAR_UPPER_X);
            radix = tuparse_pkg::BASE_HEX;
         end else if (base_reg == tuparse_pkg::BASE_AUTO && $urandom_range(0, 2) == 0) begin
            text.push_back(tuparse_pkg::CHAR_ZERO);
            radix = tuparse_pkg::BASE_OCTAL;
         end
         if (radix < tuparse_pkg::BASE_MIN || radix > tuparse_pkg::BASE_MAX) begin
            radix = tuparse_pkg::BASE_DECIMAL;
         end
         if ($urandom_range(0, 9) == 0) begin
            n = 0;
         end else if ($urandom_range(0, 3) == 0) begin
            m = ALL_ONES;
            n = 0;
            while (m != 0) begin
               m = m / radix;
               n++;
            end
            n = n - 1 + $urandom_range(0, 2);
         end else begin
            n = $urandom_range(1, 6);
         end
         repeat (n) begin
            d = $urandom_range(0, radix - 1);
            if (d < 10) begin
               text.push_back(tuparse_pkg::CHAR_ZERO + 8'(d));
            end else begin
               text.push_back(($urandom_range(0, 1) ? tuparse_pkg::CHAR_UPPER_A
                                                    : tuparse_pkg::CHAR_LOWER_A) +
                              8'(d - 10));
            end
         end
         if (text.size() == 0 || $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
         end
      end
      foreach (text[i]) begin
         send_char(text[i], i == text.size() - 1);
      end
   endtask

   task automatic test_directed();
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      send_text(" ");
      send_text("-\t5");
      send_text("+7");
      send_text("-3z");
      write_number_base(tuparse_pkg::BASE_AUTO);
      send_text("0x1F");
      send_text("0xg");
      send_text("017");
      send_text("0X");
      write_number_base(6'd63);
      send_text("5");
      write_number_base(6'd1);
      send_text("1");
   endtask

   task automatic test_value_limits();
      write_number_base(tuparse_pkg::BASE_DECIMAL);
      send_text("18446744073709551615");
      send_text("18446744073709551616");
      send_text("-18446744073709551615");
      write_number_base(tuparse_pkg::BASE_HEX);
      send_text("ffffffffffffffff");
      send_text("-0x10000000000000000");
      write_number_base(tuparse_pkg::BASE_MIN);
      send_text("-1012");
      write_number_base(tuparse_pkg::BASE_MAX);
      send_text("Zz!");
   endtask

   task automatic test_random_phases();
      int unsigned bases[$];
      int unsigned start;
      int unsigned pressure[3];
      bases = '{10, 0, 16, 2, 36, 8, 1, 37, 63, $urandom_range(0, 63), 0, 10};
      pressure = '{0, 10, 35};
      foreach (bases[p]) begin
         write_number_base(tuparse_pkg::BASE_BITS'(bases[p]));
         gap_chance = (p == bases.size() - 1) ? 0 : pressure[$urandom_range(0, 2)];
         stall_chance = (p == bases.size() - 1) ? 0 : pressure[$urandom_range(0, 2)];
         start = parsed_bytes;
         while (parsed_bytes - start < 130) send_random_string();
      end
   endtask

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      parsed_number_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_numbers.size() == 0) begin
            $display("%0t: no result expected, got value %h offset %0d", $time,
                     rsp_bus.parsed_value, rsp_bus.end_offset);
            failures++;
         end else begin
            want = expected_numbers.pop_front();
            numbers_checked++;
            check_field("parsed_value", want.value, rsp_bus.parsed_value);
            check_field("end_offset", 64'(want.offset), 64'(rsp_bus.end_offset));
            check_field("overflowed", 64'(want.overflow), 64'(rsp_bus.overflowed));
            check_field("had_digits", 64'(want.digits), 64'(rsp_bus.had_digits));
         end
      end
   end

   initial begin : result_sink
      int unsigned hold;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold != 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_chance != 0 && $urandom_range(1, 100) <= stall_chance) begin
            hold = $urandom_range(0, 14);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      failures = 0;
      parsed_bytes = 0;
      strings_sent = 0;
      numbers_checked = 0;
      gap_chance = 20;
      stall_chance = 20;
      base_reg = tuparse_pkg::BASE_RESET;
      clear_string();
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.text_byte <= '0;
      req_bus.final_byte <= 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_value_limits();
      test_random_phases();
      drain_results();
      $display("tb: %0d strings, %0d parsed bytes, %0d numbers checked", strings_sent,
               parsed_bytes, numbers_checked);
      $display("tb: radices 0 to 63 incl. invalid ones, prefixes, signs and overflow");
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
